[hdl/assert_macros.svh]
// Assertion macros shared by the replacement policy RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CWRP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CWRP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cwrp_pkg.sv]
// Types and codes shared by the replacement policy modules
`default_nettype none

package cwrp_pkg;

    typedef enum logic [1:0] {
        POL_NULL   = 2'd0,
        POL_LRU    = 2'd1,
        POL_FIFO   = 2'd2,
        POL_RANDOM = 2'd3
    } policy_t;

    typedef enum logic {
        ACT_TOUCH = 1'b0,
        ACT_FILL  = 1'b1
    } action_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS   = 2'd1;

    localparam logic [2:0] WAYS_IN_USE_RST = 3'd4;

    // Request as it travels from the input stage to the victim logic
    typedef struct packed {
        action_t    action;
        policy_t    policy;
        logic [2:0] ways_in_use;
        logic [1:0] hit_way;
        logic [3:0] valid_mask;
        logic [3:0] lock_mask;
        logic [1:0] random_way;
    } item_t;

    typedef struct packed {
        logic       found;
        logic [1:0] way;
        logic       was_valid;
    } result_t;

endpackage

`default_nettype wire

[hdl/cwrp_ram.sv]
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module cwrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/cwrp_victim.sv]
// Age update and victim selection for one set's row of ages
`default_nettype none

module cwrp_victim #(
    parameter int WAYS     = 4,
    parameter int AGE_BITS = 8
) (
    input  wire cwrp_pkg::item_t          ctl,
    input  wire logic [WAYS*AGE_BITS-1:0] row_in,
    output logic      [WAYS*AGE_BITS-1:0] row_out,
    output cwrp_pkg::result_t             res
);

    localparam int NW = $clog2(WAYS + 1);
    localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic [AGE_BITS-1:0] age     [WAYS];
    logic [AGE_BITS-1:0] aged    [WAYS];
    logic [AGE_BITS-1:0] age_mid [WAYS];
    logic [WAYS-1:0]     in_use;
    logic [WAYS+3:0]     valid_wide;
    logic [WAYS+3:0]     lock_wide;
    logic [WAYS-1:0]     vext;
    logic [WAYS-1:0]     lext;
    logic [NW-1:0]       n_ways;
    logic [1:0]          start;
    logic                found;
    logic                done;
    logic [WI-1:0]       victim;
    logic [AGE_BITS-1:0] best;
    logic [NW:0]         w;
    logic [WI+1:0]       victim_wide;

    // Ways beyond the mask width read as invalid and unlocked
    assign valid_wide = {{WAYS{1'b0}}, ctl.valid_mask};
    assign lock_wide  = {{WAYS{1'b0}}, ctl.lock_mask};
    assign vext       = valid_wide[WAYS-1:0];
    assign lext       = lock_wide[WAYS-1:0];

    always_comb begin
        if (ctl.ways_in_use == 3'd0) begin
            n_ways = NW'(1);
        end else if (32'(ctl.ways_in_use) > WAYS) begin
            n_ways = NW'(WAYS);
        end else begin
            n_ways = NW'(ctl.ways_in_use);
        end
    end

    // Random start modulo the way count; start is at most 3
    always_comb begin
        if (32'(n_ways) > 32'(ctl.random_way)) begin
            start = ctl.random_way;
        end else if (32'(n_ways) == 2) begin
            start = ctl.random_way - 2'd2;
        end else begin
            start = 2'd0;
        end
    end

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            age[i]    = row_in[i*AGE_BITS +: AGE_BITS];
            aged[i]   = (age[i] == AGE_MAX) ? AGE_MAX : age[i] + 1'b1;
            in_use[i] = (i < 32'(n_ways));
        end
    end

    always_comb begin
        found = 1'b0;
        done  = 1'b0;
        victim = '0;
        best  = '0;
        w     = '0;
        for (int i = 0; i < WAYS; i++) begin
            age_mid[i] = age[i];
        end
        if (ctl.action == cwrp_pkg::ACT_TOUCH) begin
            if (ctl.policy == cwrp_pkg::POL_LRU) begin
                for (int i = 0; i < WAYS; i++) begin
                    if (in_use[i]) begin
                        age_mid[i] = (32'(ctl.hit_way) == 32'(i)) ? '0 : aged[i];
                    end
                end
            end
        end else begin
            case (ctl.policy)
                cwrp_pkg::POL_NULL: begin
                    found = !lext[0];
                end
                cwrp_pkg::POL_LRU: begin
                    for (int i = 0; i < WAYS; i++) begin
                        if (in_use[i] && !done) begin
                            if (!vext[i]) begin
                                found  = 1'b1;
                                victim = WI'(i);
                                done   = 1'b1;
                            end else if (!lext[i] && age[i] > best) begin
                                found  = 1'b1;
                                victim = WI'(i);
                                best   = age[i];
                            end
                        end
                    end
                end
                cwrp_pkg::POL_FIFO: begin
                    // age every way in use first, then take the oldest unlocked
                    for (int i = 0; i < WAYS; i++) begin
                        if (in_use[i]) begin
                            age_mid[i] = aged[i];
                            if (!lext[i] && (!found || aged[i] > best)) begin
                                found  = 1'b1;
                                victim = WI'(i);
                                best   = aged[i];
                            end
                        end
                    end
                end
                cwrp_pkg::POL_RANDOM: begin
                    for (int i = 0; i < WAYS; i++) begin
                        if (in_use[i] && !found && !vext[i]) begin
                            found  = 1'b1;
                            victim = WI'(i);
                        end
                    end
                    // scan upward from the start, wrapping at the way count
                    for (int k = 0; k < WAYS; k++) begin
                        if (!found && (k < 32'(n_ways))) begin
                            w = (NW+1)'(start) + (NW+1)'(k);
                            if (w >= {1'b0, n_ways}) begin
                                w = w - {1'b0, n_ways};
                            end
                            if (!lext[w[WI-1:0]]) begin
                                found  = 1'b1;
                                victim = w[WI-1:0];
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            row_out[i*AGE_BITS +: AGE_BITS] =
                (found && (32'(victim) == 32'(i))) ? '0 : age_mid[i];
        end
    end

    assign victim_wide   = {2'b00, victim};
    assign res.found     = found;
    assign res.way       = found ? victim_wide[1:0] : 2'b00;
    assign res.was_valid = found & vext[victim];

endmodule

`default_nettype wire

[hdl/cache_way_replacement_policy.sv]
// Top level of the cache way replacement policy block
// One item is accepted per clock when results are taken: its set's row of ages is read from the
// age RAM at acceptance, then updated and written back when the item advances to the output, and
// the result is registered in the output word as it advances. A forwarding register covers an
// item that hits the same set as the one just before it. After reset the block clears the age
// RAM, one set per cycle, and accepts no items until that sweep ends; configuration writes are
// taken at any time but must be made while the block is idle.
`default_nettype none
`include "assert_macros.svh"

module cache_way_replacement_policy #(
    parameter int WAYS     = 4,
    parameter int SETS     = 64,
    parameter int AGE_BITS = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cwrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cwrp_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_action,
    input  wire logic [5:0]                      s_set_index,
    input  wire logic [1:0]                      s_hit_way,
    input  wire logic [3:0]                      s_valid_mask,
    input  wire logic [3:0]                      s_lock_mask,
    input  wire logic [1:0]                      s_random_way,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_victim_found,
    output logic [1:0]                           m_victim_way,
    output logic                                 m_victim_was_valid
);

    localparam int AW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ROW_W = WAYS * AGE_BITS;

    cwrp_pkg::policy_t   policy_reg;
    logic [2:0]          ways_reg;

    logic                clr_active_reg;
    logic [AW-1:0]       clr_addr_reg;

    logic                st1_valid_reg;
    cwrp_pkg::item_t     st1_item_reg;
    logic [AW-1:0]       st1_set_reg;

    logic                fwd_sel_reg;
    logic [ROW_W-1:0]    fwd_row_reg;

    logic                m_valid_reg;
    cwrp_pkg::result_t   m_res_reg;

    logic                s_fire;
    logic                st1_adv;
    logic                fwd_sel_next;
    logic [AW-1:0]       set_addr;
    cwrp_pkg::item_t     item_in;
    logic [ROW_W-1:0]    ram_rdata;
    logic [ROW_W-1:0]    row_cur;
    logic [ROW_W-1:0]    row_new;
    cwrp_pkg::result_t   res_new;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;

    assign cfg_ready = 1'b1;

    assign st1_adv = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clr_active_reg && (!st1_valid_reg || st1_adv);
    assign s_fire  = s_valid && s_ready;

    // Set index modulo the set count
    always_comb begin
        set_addr = '0;
        for (int j = 0; j < 64; j++) begin
            if (s_set_index == 6'(j)) begin
                set_addr = AW'(j % SETS);
            end
        end
    end

    assign item_in.action      = cwrp_pkg::action_t'(s_action);
    assign item_in.policy      = policy_reg;
    assign item_in.ways_in_use = ways_reg;
    assign item_in.hit_way     = s_hit_way;
    assign item_in.valid_mask  = s_valid_mask;
    assign item_in.lock_mask   = s_lock_mask;
    assign item_in.random_way  = s_random_way;

    // Forward when the write-back in flight targets the set being read
    assign fwd_sel_next = st1_adv && (st1_set_reg == set_addr);

    assign ram_we    = clr_active_reg || st1_adv;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : st1_set_reg;
    assign ram_wdata = clr_active_reg ? '0 : row_new;

    cwrp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_age_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_fire),
        .raddr (set_addr),
        .rdata (ram_rdata)
    );

    assign row_cur = fwd_sel_reg ? fwd_row_reg : ram_rdata;

    cwrp_victim #(
        .WAYS     (WAYS),
        .AGE_BITS (AGE_BITS)
    ) u_victim (
        .ctl     (st1_item_reg),
        .row_in  (row_cur),
        .row_out (row_new),
        .res     (res_new)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg     <= cwrp_pkg::POL_LRU;
            ways_reg       <= cwrp_pkg::WAYS_IN_USE_RST;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            st1_valid_reg  <= 1'b0;
            fwd_sel_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == cwrp_pkg::REG_POLICY) begin
                    policy_reg <= cwrp_pkg::policy_t'(cfg_data[1:0]);
                end else if (cfg_index == cwrp_pkg::REG_WAYS) begin
                    ways_reg <= cfg_data[2:0];
                end
            end
            // sweep the age RAM once after reset
            if (clr_active_reg) begin
                if (clr_addr_reg == AW'(SETS - 1)) begin
                    clr_active_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end
            if (s_fire) begin
                st1_valid_reg <= 1'b1;
                fwd_sel_reg   <= fwd_sel_next;
            end else if (st1_adv) begin
                st1_valid_reg <= 1'b0;
            end
            if (st1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_item_reg <= item_in;
            st1_set_reg  <= set_addr;
            fwd_row_reg  <= row_new;
        end
        if (st1_adv) begin
            m_res_reg <= res_new;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_victim_found     = m_res_reg.found;
    assign m_victim_way       = m_res_reg.way;
    assign m_victim_was_valid = m_res_reg.was_valid;

    `CWRP_ASSERT_NOW(a_no_accept_in_clear, aclk, aresetn, clr_active_reg, !s_ready,
        "word accepted during age RAM clearing")
    `CWRP_ASSERT_NXT(a_adv_loads_output, aclk, aresetn, st1_adv, m_valid_reg,
        "result advanced but output word not valid")
    `CWRP_ASSERT_NXT(a_fwd_same_set, aclk, aresetn,
        s_fire && st1_adv && (st1_set_reg == set_addr), fwd_sel_reg,
        "back-to-back access to one set not forwarded")
    `CWRP_ASSERT_NXT(a_clear_ends, aclk, aresetn,
        clr_active_reg && (clr_addr_reg == AW'(SETS - 1)), !clr_active_reg,
        "clearing pass did not finish")

endmodule

`default_nettype wire
